// File: src/adsr_wavetable_beep_generator_assert.svh
// Assertion macros shared by the checker of the beep generator.
`ifndef ADSR_WAVETABLE_BEEP_GENERATOR_ASSERT_SVH
`define ADSR_WAVETABLE_BEEP_GENERATOR_ASSERT_SVH

// Condition this cycle implies a condition on the next cycle.
`define AST_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("next-cycle check failed");

// Condition implies another condition in the same cycle.
`define AST_SAME(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("same-cycle check failed");

`endif

// File: src/adsr_pkg.sv
// Types and constants of the beep generator.
package adsr_pkg;

	// request codes of the input word
	typedef enum logic [1:0] {
		REQ_TICK = 2'd0,
		REQ_NOTE = 2'd1,
		REQ_AUTO = 2'd2,
		REQ_WAVE = 2'd3
	} req_t;

	// envelope phases
	typedef enum logic [2:0] {
		PH_ATTACK  = 3'd0,
		PH_DECAY   = 3'd1,
		PH_SUSTAIN = 3'd2,
		PH_RELEASE = 3'd3,
		PH_PAUSE   = 3'd4
	} env_t;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 15;
	localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_STEP   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_PEAK   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DECAY_STEP    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN_LEVEL = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_STEP  = 3'd4;

	// field and state widths
	localparam int FREQ_W  = 24;
	localparam int MS_W    = 16;
	localparam int TICK_W  = 22;
	localparam int CNT_W   = 10;
	localparam int SMP_W   = 16;
	localparam int LVL_W   = 15;
	localparam int PROD_W  = 41;
	localparam int MPL_W   = 16;

	// chirp constants
	localparam logic [10:0] CHIRP_BASE = 11'd1400;
	localparam logic [5:0]  VOL_LIMIT  = 6'd32;
	localparam logic [LVL_W-1:0] LVL_MAX = 15'h7FFF;

endpackage

// File: src/adsr_wavetable_beep_generator.sv
// Top level of the envelope wavetable beep generator.
//
// Usage: one input channel (in_valid/in_ready) carries request words: a sample
// tick, a note to queue, an autotune count or a wave table entry. Only a tick
// yields an output word (out_valid/out_ready) with the sample and the active
// flag. Configuration registers are written through cfg_we/cfg_index/cfg_wdata
// while the block is idle: a rule for the user, not enforced by the block;
// indexes beyond the register list are ignored. A silent tick goes straight to
// the output stage; a chirp tick runs two 16-step shift-add multiplies (phase
// increment, then sample scaling) around a 13-step restoring remainder for the
// wave index with the default depth (23 - clog2(WAVE_DEPTH+1) + 1 steps); an
// envelope tick first steps the envelope and reads the note. Queue and autotune
// words leave the input open; a wave write closes it until the entry is written.
// One word is worked on at a time; the next word is taken while a finished
// result still waits in the output register. When the receiver stalls, the
// result holds and a following tick waits at its last cycle for the slot.
// Reset clears pointers, envelope, phase, counts and the output register and
// loads the register defaults; note and wave memories are undefined until
// written and need no clearing.
module adsr_wavetable_beep_generator #(
	parameter int QUEUE_DEPTH = 256,
	parameter int WAVE_DEPTH  = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [adsr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [adsr_pkg::CFG_W-1:0]          cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          req_type,
	input  logic [adsr_pkg::FREQ_W-1:0]         freq_step,
	input  logic [adsr_pkg::MS_W-1:0]           duration_ms,
	input  logic [adsr_pkg::MS_W-1:0]           pause_ms,
	input  logic [adsr_pkg::CNT_W-1:0]          autotune_count,
	input  logic [9:0]                          wave_index,
	input  logic signed [adsr_pkg::SMP_W-1:0]   wave_value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [adsr_pkg::SMP_W-1:0]   sample,
	output logic                                active
);
	import adsr_pkg::*;

	localparam int QW        = $clog2(QUEUE_DEPTH);
	localparam int WW        = $clog2(WAVE_DEPTH);
	localparam int KTOP      = 23 - $clog2(WAVE_DEPTH + 1);
	localparam int MOD_STEPS = KTOP + 1;
	localparam logic [23:0] DV_INIT = 24'(WAVE_DEPTH) << KTOP;
	localparam logic [QW-1:0] QLAST = QW'(QUEUE_DEPTH - 1);

	typedef enum logic [3:0] {
		S_IDLE, S_ENV, S_FRD, S_INCS, S_MULI, S_INCA, S_MODR, S_WRD,
		S_SMPS, S_MULS, S_FIN, S_OUT, S_MODW, S_WWR
	} state_t;

	state_t state_q;

	// configuration registers
	logic [LVL_W-1:0] attack_step_q, attack_peak_q, decay_step_q;
	logic [LVL_W-1:0] sustain_level_q, release_step_q;

	// control state
	logic [QW-1:0]     rp_q, wp_q;
	env_t              phase_q;
	logic [LVL_W-1:0]  lvl_q;
	logic [TICK_W-1:0] tc_q;
	logic [31:0]       ph_q;
	logic [CNT_W-1:0]  chirp_q;
	logic              playing_q;
	logic              chirp_mode_q;
	logic signed [SMP_W-1:0] held_q;
	logic              ovalid_q;
	logic signed [SMP_W-1:0] sample_q;
	logic              active_q;

	// serial multiplier and remainder registers
	logic signed [PROD_W-1:0] mc_q, acc_q;
	logic [MPL_W-1:0]         mp_q;
	logic [3:0]               mcnt_q;
	logic [TICK_W-1:0]        rem_q;
	logic [23:0]              dv_q;
	logic [4:0]               rcnt_q;
	logic signed [SMP_W-1:0]  wval_q;

	// memories
	logic [FREQ_W-1:0]     freq_mem [QUEUE_DEPTH];
	logic [2*TICK_W-1:0]   time_mem [QUEUE_DEPTH];
	logic signed [SMP_W-1:0] wave_mem [WAVE_DEPTH];
	logic [FREQ_W-1:0]     fdata_q;
	logic [2*TICK_W-1:0]   tdata_q;
	logic signed [SMP_W-1:0] wdata_q;

	logic              accept;
	logic              note_we;
	logic              wave_we;
	logic [TICK_W-1:0] dur48, pause48;
	logic [WW-1:0]     widx;

	// envelope next-state values
	env_t              phase_n;
	logic [LVL_W-1:0]  lvl_n;
	logic [TICK_W-1:0] tc_n;
	logic [QW-1:0]     rp_n;
	logic              playing_n;
	logic [16:0]       up_sum;
	logic signed [16:0] dn_dec, dn_rel;
	logic [TICK_W-1:0] tc_inc;
	logic [QW-1:0]     rp_inc;

	logic [10:0]       chirp_d;
	logic [5:0]        vol_raw;
	logic [MPL_W-1:0]  vol;
	logic [31:0]       inc;
	logic [31:0]       ph_n;
	logic signed [PROD_W-1:0] q14, q15;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign note_we   = accept && (req_type == REQ_NOTE);
	assign wave_we   = (state_q == S_WWR);
	assign out_valid = ovalid_q;
	assign sample    = sample_q;
	assign active    = active_q;
	assign widx      = WW'(rem_q);

	// scale milliseconds to ticks: times 48 as two shifts
	assign dur48   = (TICK_W'(duration_ms) << 5) + (TICK_W'(duration_ms) << 4);
	assign pause48 = (TICK_W'(pause_ms) << 5) + (TICK_W'(pause_ms) << 4);

	// hold note memories, read at the read pointer every cycle
	always_ff @(posedge clk) begin
		if (note_we) begin
			freq_mem[wp_q] <= freq_step;
			time_mem[wp_q] <= {dur48, pause48};
		end
		fdata_q <= freq_mem[rp_q];
		tdata_q <= time_mem[rp_q];
	end

	// hold wave table, read at the reduced index every cycle
	always_ff @(posedge clk) begin
		if (wave_we) begin
			wave_mem[widx] <= wval_q;
		end
		wdata_q <= wave_mem[widx];
	end

	// step the envelope by one tick
	always_comb begin
		up_sum  = {2'b00, lvl_q} + {2'b00, attack_step_q};
		dn_dec  = $signed({2'b00, lvl_q}) - $signed({2'b00, decay_step_q});
		dn_rel  = $signed({2'b00, lvl_q}) - $signed({2'b00, release_step_q});
		tc_inc  = tc_q + TICK_W'(1);
		rp_inc  = (rp_q == QLAST) ? '0 : rp_q + QW'(1);
		phase_n   = phase_q;
		lvl_n     = lvl_q;
		tc_n      = tc_q;
		rp_n      = rp_q;
		playing_n = playing_q;
		unique case (phase_q)
			PH_ATTACK: begin
				if (up_sum >= {2'b00, attack_peak_q}) begin
					lvl_n   = attack_peak_q;
					phase_n = PH_DECAY;
				end else begin
					lvl_n = up_sum[LVL_W-1:0];
				end
			end
			PH_DECAY: begin
				if (dn_dec <= $signed({2'b00, sustain_level_q})) begin
					lvl_n   = sustain_level_q;
					phase_n = PH_SUSTAIN;
					tc_n    = '0;
				end else begin
					lvl_n = dn_dec[LVL_W-1:0];
				end
			end
			PH_SUSTAIN: begin
				tc_n = tc_inc;
				if (tc_inc >= tdata_q[2*TICK_W-1:TICK_W]) begin
					phase_n = PH_RELEASE;
				end
			end
			PH_RELEASE: begin
				if (dn_rel <= 17'sd0) begin
					lvl_n   = '0;
					tc_n    = '0;
					phase_n = PH_PAUSE;
				end else begin
					lvl_n = dn_rel[LVL_W-1:0];
				end
			end
			default: begin
				tc_n = tc_inc;
				if (tc_inc >= tdata_q[TICK_W-1:0]) begin
					phase_n = PH_ATTACK;
					rp_n    = rp_inc;
					if (rp_inc == wp_q) begin
						playing_n = 1'b0;
					end
				end
			end
		endcase
	end

	// chirp distance, stepped volume, phase increment and rounding toward zero
	always_comb begin
		chirp_d = CHIRP_BASE - 11'(chirp_q);
		vol_raw = chirp_q[5:0];
		vol     = (vol_raw > VOL_LIMIT) ? '0 : MPL_W'({vol_raw, 8'h00});
		inc     = chirp_mode_q ? 32'(acc_q >>> 5) : 32'(acc_q >>> 23);
		ph_n    = ph_q + inc;
		q14     = (acc_q < 0) ? ((acc_q + PROD_W'(16383)) >>> 14) : (acc_q >>> 14);
		q15     = (acc_q < 0) ? ((acc_q + PROD_W'(32767)) >>> 15) : (acc_q >>> 15);
	end

	// sequence one word and hold the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			attack_step_q   <= 15'd64;
			attack_peak_q   <= 15'd32767;
			decay_step_q    <= 15'd16;
			sustain_level_q <= 15'd16384;
			release_step_q  <= 15'd32;
			rp_q            <= '0;
			wp_q            <= '0;
			phase_q         <= PH_ATTACK;
			lvl_q           <= '0;
			tc_q            <= '0;
			ph_q            <= '0;
			chirp_q         <= '0;
			playing_q       <= 1'b0;
			chirp_mode_q    <= 1'b0;
			held_q          <= '0;
			ovalid_q        <= 1'b0;
			sample_q        <= '0;
			active_q        <= 1'b0;
			mcnt_q          <= '0;
			rcnt_q          <= '0;
		end else begin
			// take configuration writes
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_ATTACK_STEP:   attack_step_q   <= cfg_wdata;
					CFG_ATTACK_PEAK:   attack_peak_q   <= cfg_wdata;
					CFG_DECAY_STEP:    decay_step_q    <= cfg_wdata;
					CFG_SUSTAIN_LEVEL: sustain_level_q <= cfg_wdata;
					CFG_RELEASE_STEP:  release_step_q  <= cfg_wdata;
					default: ;
				endcase
			end
			// drop the output word once taken, unless a new one replaces it
			if (ovalid_q && out_ready && (state_q != S_OUT)) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (req_type)
							REQ_NOTE: begin
								wp_q      <= (wp_q == QLAST) ? '0 : wp_q + QW'(1);
								playing_q <= 1'b1;
							end
							REQ_AUTO: begin
								chirp_q   <= autotune_count;
								playing_q <= (autotune_count != '0);
							end
							REQ_WAVE: begin
								rem_q   <= TICK_W'(wave_index);
								wval_q  <= wave_value;
								dv_q    <= DV_INIT;
								rcnt_q  <= '0;
								state_q <= S_MODW;
							end
							default: begin
								chirp_mode_q <= (chirp_q != '0);
								if (!playing_q) begin
									state_q <= S_OUT;
								end else if (chirp_q != '0) begin
									mc_q    <= PROD_W'(chirp_d);
									mp_q    <= MPL_W'(chirp_d);
									acc_q   <= '0;
									mcnt_q  <= '0;
									state_q <= S_MULI;
								end else begin
									state_q <= S_ENV;
								end
							end
						endcase
					end
				end
				S_ENV: begin
					phase_q   <= phase_n;
					lvl_q     <= lvl_n;
					tc_q      <= tc_n;
					rp_q      <= rp_n;
					playing_q <= playing_n;
					state_q   <= S_FRD;
				end
				S_FRD: begin
					state_q <= S_INCS;
				end
				S_INCS: begin
					mc_q    <= playing_q ? PROD_W'(fdata_q) : '0;
					mp_q    <= MPL_W'(LVL_MAX - lvl_q);
					acc_q   <= '0;
					mcnt_q  <= '0;
					state_q <= S_MULI;
				end
				S_MULI, S_MULS: begin
					// add one multiplier bit per cycle
					if (mp_q[0]) begin
						acc_q <= acc_q + mc_q;
					end
					mc_q   <= mc_q <<< 1;
					mp_q   <= mp_q >> 1;
					mcnt_q <= mcnt_q + 4'd1;
					if (mcnt_q == 4'd15) begin
						state_q <= (state_q == S_MULI) ? S_INCA : S_FIN;
					end
				end
				S_INCA: begin
					ph_q    <= ph_n;
					rem_q   <= ph_n[31:10];
					dv_q    <= DV_INIT;
					rcnt_q  <= '0;
					state_q <= S_MODR;
				end
				S_MODR, S_MODW: begin
					// reduce the index by one restoring step
					if ({2'b00, rem_q} >= dv_q) begin
						rem_q <= rem_q - dv_q[TICK_W-1:0];
					end
					dv_q   <= dv_q >> 1;
					rcnt_q <= rcnt_q + 5'd1;
					if (rcnt_q == 5'(MOD_STEPS - 1)) begin
						state_q <= (state_q == S_MODR) ? S_WRD : S_WWR;
					end
				end
				S_WRD: begin
					state_q <= S_SMPS;
				end
				S_SMPS: begin
					mc_q    <= PROD_W'(wdata_q);
					mp_q    <= chirp_mode_q ? vol : MPL_W'(lvl_q);
					acc_q   <= '0;
					mcnt_q  <= '0;
					state_q <= S_MULS;
				end
				S_FIN: begin
					held_q  <= chirp_mode_q ? SMP_W'(q14) : SMP_W'(q15);
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!ovalid_q || out_ready) begin
						ovalid_q <= 1'b1;
						sample_q <= held_q;
						active_q <= playing_q;
						state_q  <= S_IDLE;
					end
				end
				S_WWR: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: src/adsr_chk.sv
// Port checker of the beep generator and its bind.
`include "adsr_wavetable_beep_generator_assert.svh"

module adsr_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic [1:0]                        req_type,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic signed [adsr_pkg::SMP_W-1:0] sample,
	input logic                              active
);
	import adsr_pkg::*;

	// hold a stalled output word
	`AST_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(sample) && $stable(active))

	// an accepted tick closes the input in the next cycle
	`AST_NEXT(a_tick_busy, in_valid && in_ready && (req_type == REQ_TICK), !in_ready)

	// a queued note leaves the input open
	`AST_NEXT(a_note_open, in_valid && in_ready && (req_type == REQ_NOTE), in_ready)

endmodule

bind adsr_wavetable_beep_generator adsr_chk u_adsr_chk (.*);
